>>> rtl/sfl_pkg.sv
// Shared constants, codes and control structs of the size-class free list.
package sfl_pkg;

   localparam int SIZE_CLASSES = 16;
   localparam int CLASS_BITS   = $clog2(SIZE_CLASSES);
   localparam int ADDRESS_BITS = 10;
   localparam int LINK_BITS    = ADDRESS_BITS + 1;
   localparam int SIZE_BITS    = 16;
   localparam logic [SIZE_BITS-1:0] MIN_SIZE_RESET = SIZE_BITS'(8);

   typedef enum logic [1:0] {
      MODE_QUERY = 2'd0,
      MODE_TAKE  = 2'd1,
      MODE_GIVE  = 2'd2,
      MODE_CLEAR = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_TOO_SMALL = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_POP
   } state_type;

   typedef enum logic [2:0] {
      CLS_NONE,
      CLS_SET_HEAD,
      CLS_ALLOC,
      CLS_RETIRE,
      CLS_CLEAR
   } class_op_type;

   typedef struct packed {
      logic                    hit;
      logic [CLASS_BITS-1:0]   hit_idx;
      logic                    free_ok;
      logic [CLASS_BITS-1:0]   free_idx;
      logic [ADDRESS_BITS-1:0] head;
   } class_lookup_type;

   typedef struct packed {
      class_op_type            op;
      logic [CLASS_BITS-1:0]   idx;
      logic [SIZE_BITS-1:0]    size;
      logic [ADDRESS_BITS-1:0] head;
   } class_update_type;

endpackage

>>> rtl/sfl_if.sv
// Request and response channel interfaces of the size-class free list.
interface sfl_req_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        mode;
   logic [sfl_pkg::SIZE_BITS-1:0]     block_size;
   logic [sfl_pkg::ADDRESS_BITS-1:0]  block_address;

   modport source (output valid, mode, block_size, block_address, input ready);
   modport sink (input valid, mode, block_size, block_address, output ready);
endinterface

interface sfl_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              found;
   logic [sfl_pkg::ADDRESS_BITS-1:0]  taken_address;
   logic [1:0]                        status;

   modport source (output valid, found, taken_address, status, input ready);
   modport sink (input valid, found, taken_address, status, output ready);
endinterface

>>> rtl/sfl_link_ram.sv
// Single-port-write, single-port-read RAM with registered read.
module sfl_link_ram #(
   parameter int ADDR_BITS = 10,
   parameter int DATA_BITS = 11
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem_ff [2**ADDR_BITS];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/sfl_class_table.sv
// Size-class table: size match, free-entry search and head/valid updates.
module sfl_class_table (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [sfl_pkg::SIZE_BITS-1:0]     lookup_size,
   output sfl_pkg::class_lookup_type         lookup,
   input  sfl_pkg::class_update_type         update
);

   logic                              valid_ff [sfl_pkg::SIZE_CLASSES];
   logic [sfl_pkg::SIZE_BITS-1:0]     size_ff  [sfl_pkg::SIZE_CLASSES];
   logic [sfl_pkg::ADDRESS_BITS-1:0]  head_ff  [sfl_pkg::SIZE_CLASSES];

   always_comb begin
      lookup = '0;
      for (int i = sfl_pkg::SIZE_CLASSES - 1; i >= 0; i--) begin
         if (valid_ff[i] && size_ff[i] == lookup_size) begin
            lookup.hit     = 1'b1;
            lookup.hit_idx = sfl_pkg::CLASS_BITS'(i);
         end
         if (!valid_ff[i]) begin
            lookup.free_ok  = 1'b1;
            lookup.free_idx = sfl_pkg::CLASS_BITS'(i);
         end
      end
      lookup.head = head_ff[lookup.hit_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < sfl_pkg::SIZE_CLASSES; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         case (update.op)
            sfl_pkg::CLS_ALLOC:  valid_ff[update.idx] <= 1'b1;
            sfl_pkg::CLS_RETIRE: valid_ff[update.idx] <= 1'b0;
            sfl_pkg::CLS_CLEAR: begin
               for (int i = 0; i < sfl_pkg::SIZE_CLASSES; i++) begin
                  valid_ff[i] <= 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (update.op)
         sfl_pkg::CLS_ALLOC: begin
            size_ff[update.idx] <= update.size;
            head_ff[update.idx] <= update.head;
         end
         sfl_pkg::CLS_SET_HEAD: head_ff[update.idx] <= update.head;
         default: ;
      endcase
   end

endmodule

>>> rtl/size_class_free_list.sv
// Top level of the size-class free list allocator bookkeeping.
//
// req_ch carries one item per handshake: mode (query, take, give back,
// clear), block_size and block_address. rsp_ch returns exactly one item per
// request, in order: found, taken_address and status.
// csr_wr_en/csr_wr_data write min_block_size; write only while idle.
//
// Each request is registered, then executed against the size-class table
// (flip-flops, searched in parallel) and the link store (1024-entry RAM
// with a registered read). Query, give back, clear and a take that misses
// load the response from execution; a take that hits first reads the link
// of the popped head and loads its response in the pop state. A new request
// is accepted in the cycle after a response is loaded, never before.
//
// Reset empties every list and sets min_block_size to 8; the link store is
// not cleared. When rsp_ch stalls, the response register holds and the next
// request waits in execution, or in the pop state for a take that hits,
// without updating the lists until the response register frees up.
module size_class_free_list (
   input  logic                          clock,
   input  logic                          reset,
   sfl_req_if.sink                       req_ch,
   sfl_rsp_if.source                     rsp_ch,
   input  logic                          csr_wr_en,
   input  logic [sfl_pkg::SIZE_BITS-1:0] csr_wr_data
);

   sfl_pkg::state_type                state_ff, state_in;
   sfl_pkg::mode_type                 mode_ff;
   logic [sfl_pkg::SIZE_BITS-1:0]     size_ff;
   logic [sfl_pkg::ADDRESS_BITS-1:0]  addr_ff;
   logic [sfl_pkg::SIZE_BITS-1:0]     min_size_ff;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_found_ff, rsp_found_in;
   logic [sfl_pkg::ADDRESS_BITS-1:0]  rsp_taken_ff, rsp_taken_in;
   sfl_pkg::status_type               rsp_status_ff, rsp_status_in;

   sfl_pkg::class_lookup_type         lookup;
   sfl_pkg::class_update_type         update;

   logic                              ram_wr_en;
   logic [sfl_pkg::LINK_BITS-1:0]     ram_wr_data;
   logic                              ram_rd_en;
   logic [sfl_pkg::LINK_BITS-1:0]     ram_rd_data;

   logic                              out_free;
   logic                              load_rsp;
   logic                              accept;

   sfl_class_table u_class_table (
      .clock       (clock),
      .reset       (reset),
      .lookup_size (size_ff),
      .lookup      (lookup),
      .update      (update)
   );

   sfl_link_ram #(
      .ADDR_BITS (sfl_pkg::ADDRESS_BITS),
      .DATA_BITS (sfl_pkg::LINK_BITS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (addr_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (lookup.head),
      .rd_data (ram_rd_data)
   );

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign accept   = req_ch.valid && req_ch.ready;

   always_comb begin
      state_in      = state_ff;
      req_ch.ready  = 1'b0;
      update        = '0;
      update.op     = sfl_pkg::CLS_NONE;
      ram_wr_en     = 1'b0;
      ram_wr_data   = '0;
      ram_rd_en     = 1'b0;
      load_rsp      = 1'b0;
      rsp_found_in  = lookup.hit;
      rsp_taken_in  = '0;
      rsp_status_in = sfl_pkg::ST_OK;

      unique case (state_ff)
         sfl_pkg::S_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               state_in = sfl_pkg::S_EXEC;
            end
         end
         sfl_pkg::S_EXEC: begin
            case (mode_ff)
               sfl_pkg::MODE_TAKE: begin
                  if (lookup.hit) begin
                     ram_rd_en = 1'b1;
                     state_in  = sfl_pkg::S_POP;
                  end else if (out_free) begin
                     load_rsp      = 1'b1;
                     rsp_status_in = sfl_pkg::ST_EMPTY;
                     state_in      = sfl_pkg::S_IDLE;
                  end
               end
               sfl_pkg::MODE_GIVE: begin
                  if (out_free) begin
                     load_rsp = 1'b1;
                     state_in = sfl_pkg::S_IDLE;
                     if (size_ff < min_size_ff) begin
                        rsp_status_in = sfl_pkg::ST_TOO_SMALL;
                     end else if (lookup.hit) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_data = {1'b1, lookup.head};
                        update.op   = sfl_pkg::CLS_SET_HEAD;
                        update.idx  = lookup.hit_idx;
                        update.head = addr_ff;
                     end else if (lookup.free_ok) begin
                        ram_wr_en   = 1'b1;
                        update.op   = sfl_pkg::CLS_ALLOC;
                        update.idx  = lookup.free_idx;
                        update.size = size_ff;
                        update.head = addr_ff;
                     end else begin
                        rsp_status_in = sfl_pkg::ST_FULL;
                     end
                  end
               end
               sfl_pkg::MODE_CLEAR: begin
                  if (out_free) begin
                     load_rsp     = 1'b1;
                     rsp_found_in = 1'b0;
                     update.op    = sfl_pkg::CLS_CLEAR;
                     state_in     = sfl_pkg::S_IDLE;
                  end
               end
               default: begin
                  if (out_free) begin
                     load_rsp = 1'b1;
                     state_in = sfl_pkg::S_IDLE;
                  end
               end
            endcase
         end
         sfl_pkg::S_POP: begin
            if (out_free) begin
               load_rsp     = 1'b1;
               rsp_found_in = 1'b1;
               rsp_taken_in = lookup.head;
               update.idx   = lookup.hit_idx;
               state_in     = sfl_pkg::S_IDLE;
               if (ram_rd_data[sfl_pkg::ADDRESS_BITS]) begin
                  update.op   = sfl_pkg::CLS_SET_HEAD;
                  update.head = ram_rd_data[sfl_pkg::ADDRESS_BITS-1:0];
               end else begin
                  update.op = sfl_pkg::CLS_RETIRE;
               end
            end
         end
         default: state_in = sfl_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sfl_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         min_size_ff  <= sfl_pkg::MIN_SIZE_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            min_size_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= sfl_pkg::mode_type'(req_ch.mode);
         size_ff <= req_ch.block_size;
         addr_ff <= req_ch.block_address;
      end
      if (load_rsp) begin
         rsp_found_ff  <= rsp_found_in;
         rsp_taken_ff  <= rsp_taken_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.found         = rsp_found_ff;
   assign rsp_ch.taken_address = rsp_taken_ff;
   assign rsp_ch.status        = rsp_status_ff;

endmodule

>>> test/free_list_scoreboard.sv
// Scoreboard for the size-class free list: predicts each response and checks it.
module free_list_scoreboard
   import sfl_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   sfl_req_if                   req_ch,
   sfl_rsp_if                   rsp_ch,
   input  logic                 csr_wr_en,
   input  logic [SIZE_BITS-1:0] csr_wr_data,
   output int                   mismatch_count,
   output int                   awaited_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic                    found;
      logic [ADDRESS_BITS-1:0] taken_address;
      status_type              status;
   } outcome_type;

   logic                    cls_valid [SIZE_CLASSES];
   logic [SIZE_BITS-1:0]    cls_size  [SIZE_CLASSES];
   logic [ADDRESS_BITS-1:0] cls_head  [SIZE_CLASSES];
   logic [LINK_BITS-1:0]    link_mem  [1 << ADDRESS_BITS];
   logic [SIZE_BITS-1:0]    min_size;

   outcome_type due_responses [$];
   outcome_type want;
   int          errors = 0;

   assign mismatch_count = errors;

   function automatic outcome_type apply_request(input mode_type mode,
                                                 input logic [SIZE_BITS-1:0] size,
                                                 input logic [ADDRESS_BITS-1:0] addr);
      outcome_type res;
      int          hit;
      int          slot;
      logic [ADDRESS_BITS-1:0] head;
      res.found         = 1'b0;
      res.taken_address = '0;
      res.status        = ST_OK;
      hit  = -1;
      slot = -1;
      for (int i = 0; i < SIZE_CLASSES; i++) begin
         if (hit < 0 && cls_valid[i] && cls_size[i] == size) hit = i;
         if (slot < 0 && !cls_valid[i]) slot = i;
      end
      if (mode != MODE_CLEAR && hit >= 0) res.found = 1'b1;
      case (mode)
         MODE_TAKE: begin
            if (hit < 0) begin
               res.status = ST_EMPTY;
            end else begin
               head = cls_head[hit];
               res.taken_address = head;
               if (link_mem[head][ADDRESS_BITS]) begin
                  cls_head[hit] = link_mem[head][ADDRESS_BITS-1:0];
               end else begin
                  cls_valid[hit] = 1'b0;
               end
            end
         end
         MODE_GIVE: begin
            if (size < min_size) begin
               res.status = ST_TOO_SMALL;
            end else if (hit >= 0) begin
               link_mem[addr] = {1'b1, cls_head[hit]};
               cls_head[hit]  = addr;
            end else if (slot < 0) begin
               res.status = ST_FULL;
            end else begin
               cls_valid[slot] = 1'b1;
               cls_size[slot]  = size;
               cls_head[slot]  = addr;
               link_mem[addr]  = '0;
            end
         end
         MODE_CLEAR: begin
            for (int i = 0; i < SIZE_CLASSES; i++) cls_valid[i] = 1'b0;
         end
         default: ;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SIZE_CLASSES; i++) begin
            cls_valid[i] = 1'b0;
            cls_size[i]  = '0;
            cls_head[i]  = '0;
         end
         min_size = MIN_SIZE_RESET;
         due_responses.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (due_responses.size() == 0) begin
               $error("response item with no request pending");
               errors++;
            end else begin
               want = due_responses.pop_front();
               if (rsp_ch.found !== want.found) begin
                  $error("found: expected %0d, got %0d", want.found, rsp_ch.found);
                  errors++;
               end
               if (rsp_ch.taken_address !== want.taken_address) begin
                  $error("taken_address: expected %0d, got %0d",
                         want.taken_address, rsp_ch.taken_address);
                  errors++;
               end
               if (rsp_ch.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                  errors++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            due_responses.push_back(apply_request(mode_type'(req_ch.mode),
                                                  req_ch.block_size,
                                                  req_ch.block_address));
         end
         if (csr_wr_en) min_size = csr_wr_data;
      end
      awaited_count <= due_responses.size();
   end

endmodule

>>> test/tb_size_class_free_list.sv
// Testbench top for the size-class free list: clock, reset, stimulus and verdict.
module tb_size_class_free_list;
   timeunit 1ns;
   timeprecision 1ps;
   import sfl_pkg::*;

   localparam int CLOCK_PERIOD   = 20;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 400;
   localparam int POOL_DEPTH     = 20;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_wr_en = 1'b0;
   logic [SIZE_BITS-1:0] csr_wr_data = '0;

   int  mismatches;
   int  awaited;
   int  quiet_cycles = 0;
   int  mode_count [4] = '{0, 0, 0, 0};
   int  items_sent = 0;
   bit  send_idle = 1'b0;
   bit  recv_idle = 1'b0;
   bit  hold_rsp = 1'b0;
   logic [SIZE_BITS-1:0] size_pool [POOL_DEPTH];
   logic [SIZE_BITS-1:0] mid_min;

   sfl_req_if req_ch ();
   sfl_rsp_if rsp_ch ();

   size_class_free_list u_top (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   free_list_scoreboard u_scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatches),
      .awaited_count  (awaited)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || csr_wr_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (recv_idle && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   task automatic send_item(input mode_type mode, input logic [SIZE_BITS-1:0] size,
                            input logic [ADDRESS_BITS-1:0] addr);
      if (send_idle && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.mode          <= mode;
      req_ch.block_size    <= size;
      req_ch.block_address <= addr;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      mode_count[mode]++;
      items_sent++;
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (awaited != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_min_size(input logic [SIZE_BITS-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
   endtask

   // cluster sizes around the threshold so lists get reused and the table fills
   task automatic fill_pool(input logic [SIZE_BITS-1:0] threshold);
      int v;
      for (int i = 0; i < POOL_DEPTH; i++) begin
         v = int'(threshold) + $urandom_range(0, 27) - 4;
         if (v < 0) v = 0;
         if (v > 65535) v = 65535;
         size_pool[i] = SIZE_BITS'(v);
      end
   endtask

   task automatic random_item();
      mode_type                mode;
      logic [SIZE_BITS-1:0]    size;
      logic [ADDRESS_BITS-1:0] addr;
      int                      pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) mode = MODE_GIVE;
      else if (pick < 75) mode = MODE_TAKE;
      else if (pick < 99) mode = MODE_QUERY;
      else mode = MODE_CLEAR;
      if ($urandom_range(0, 9) < 8) size = size_pool[$urandom_range(0, POOL_DEPTH - 1)];
      else size = SIZE_BITS'($urandom);
      if ($urandom_range(0, 1) == 1) addr = ADDRESS_BITS'($urandom);
      else addr = ADDRESS_BITS'($urandom_range(0, 15));
      send_item(mode, size, addr);
   endtask

   task automatic directed_items();
      send_item(MODE_TAKE, 16'd8, '0);
      send_item(MODE_GIVE, 16'd7, 10'd3);
      send_item(MODE_GIVE, 16'd8, 10'd0);
      send_item(MODE_GIVE, 16'd8, 10'd1023);
      send_item(MODE_QUERY, 16'd8, '0);
      send_item(MODE_TAKE, 16'd8, '0);
      send_item(MODE_TAKE, 16'd8, '0);
      send_item(MODE_TAKE, 16'd8, '0);
      for (int i = 0; i < SIZE_CLASSES; i++) begin
         send_item(MODE_GIVE, 16'hFFFF - SIZE_BITS'(i), ADDRESS_BITS'(i * 67));
      end
      send_item(MODE_GIVE, 16'd8, 10'd512);
      send_item(MODE_CLEAR, 16'hFFFF, 10'd1023);
   endtask

   initial begin
      req_ch.valid         = 1'b0;
      req_ch.mode          = MODE_QUERY;
      req_ch.block_size    = '0;
      req_ch.block_address = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      send_idle = 1'b1;
      recv_idle = 1'b1;

      directed_items();

      settle();
      write_min_size('0);
      fill_pool('0);
      repeat (600) random_item();

      settle();
      write_min_size(16'hFFFF);
      fill_pool(16'hFFFF);
      repeat (150) random_item();

      settle();
      mid_min = SIZE_BITS'($urandom_range(16, 4096));
      write_min_size(mid_min);
      fill_pool(mid_min);
      hold_rsp = 1'b1;
      repeat (600) random_item();

      settle();
      send_idle = 1'b0;
      recv_idle = 1'b0;
      write_min_size(MIN_SIZE_RESET);
      fill_pool(MIN_SIZE_RESET);
      repeat (350) random_item();

      settle();
      $display("Ran %0d items: %0d queries, %0d takes, %0d give-backs, %0d clears",
               items_sent, mode_count[MODE_QUERY], mode_count[MODE_TAKE],
               mode_count[MODE_GIVE], mode_count[MODE_CLEAR]);
      $display("min_block_size went 8, 0, 65535, %0d, 8; one long response hold-off",
               mid_min);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/sfl_pkg.sv
rtl/sfl_if.sv
rtl/sfl_link_ram.sv
rtl/sfl_class_table.sv
rtl/size_class_free_list.sv
test/free_list_scoreboard.sv
test/tb_size_class_free_list.sv
